>>> rtl/core/srfb_pkg.sv
`default_nettype none

package srfb_pkg;

  // Action codes carried by an input item.
  typedef enum logic [1:0] {
    ACT_RX_BYTE = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_READ    = 2'd2,
    ACT_REPORT  = 2'd3
  } srfb_action_e;

  // Result kinds.
  localparam logic KIND_TX_BYTE   = 1'b0;
  localparam logic KIND_READ_WORD = 1'b1;

  // Frame constants.
  localparam logic [7:0] HDR_HI    = 8'h5A;
  localparam logic [7:0] HDR_LO    = 8'hA5;
  localparam logic [7:0] CMD_WRITE = 8'h82;
  localparam logic [7:0] CMD_READ  = 8'h83;

  // Word addresses carry one extra bit so that a base plus an offset never wraps.
  localparam int unsigned XADDR_W = 17;

  // Write request towards the register store.
  typedef struct packed {
    logic                 en;
    logic [XADDR_W-1:0]   addr;
    logic [15:0]          data;
  } srfb_wr_t;

  // Read request towards the register store.
  typedef struct packed {
    logic                 en;
    logic [XADDR_W-1:0]   addr;
  } srfb_rd_t;

  // Request to transmit a report frame.
  typedef struct packed {
    logic        en;
    logic [15:0] addr;
    logic [7:0]  count;
  } srfb_rpt_t;

endpackage

`default_nettype wire

>>> rtl/core/srfb_if.sv
`default_nettype none

// Input channel: one action per item.
interface srfb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  rx_byte;
  logic [15:0] reg_addr;
  logic [15:0] reg_value;
  logic [7:0]  reg_count;

  modport source (output valid, action, rx_byte, reg_addr, reg_value, reg_count,
                  input ready);
  modport sink   (input valid, action, rx_byte, reg_addr, reg_value, reg_count,
                  output ready);
endinterface

// Output channel: one transmitted byte or one read word per item.
interface srfb_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  tx_byte;
  logic [15:0] read_word;
  logic        frame_last;

  modport source (output valid, out_kind, tx_byte, read_word, frame_last,
                  input ready);
  modport sink   (input valid, out_kind, tx_byte, read_word, frame_last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/srfb_store.sv
`default_nettype none

// Register store: one write port, one registered read port, and a clearing
// sweep after reset. Accesses beyond the top of the store are ignored on write
// and read back as zero.
module srfb_store #(
  parameter int unsigned REG_WORDS = 2048
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  srfb_pkg::srfb_wr_t   wr_i,
  input  srfb_pkg::srfb_rd_t   rd_i,
  output logic [15:0]          rdata_o,
  output logic                 busy_o
);

  localparam int unsigned AW = $clog2(REG_WORDS);

  logic [15:0]   mem [REG_WORDS];
  logic [15:0]   rdata_raw_q;
  logic          oob_q, oob_d;
  logic          busy_q, busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          wr_in_range;

  assign wr_in_range = wr_i.addr < srfb_pkg::XADDR_W'(REG_WORDS);

  always_comb begin
    busy_d     = busy_q;
    clr_addr_d = clr_addr_q;
    if (busy_q) begin
      mem_we     = 1'b1;
      mem_waddr  = clr_addr_q;
      mem_wdata  = '0;
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(REG_WORDS - 1)) begin
        busy_d = 1'b0;
      end
    end else begin
      mem_we    = wr_i.en && wr_in_range;
      mem_waddr = wr_i.addr[AW-1:0];
      mem_wdata = wr_i.data;
    end
    oob_d = oob_q;
    if (rd_i.en) begin
      oob_d = rd_i.addr >= srfb_pkg::XADDR_W'(REG_WORDS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_i.en) begin
      rdata_raw_q <= mem[rd_i.addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
      oob_q      <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
      oob_q      <= oob_d;
    end
  end

  assign rdata_o = oob_q ? 16'h0000 : rdata_raw_q;
  assign busy_o  = busy_q;

endmodule

`default_nettype wire

>>> rtl/core/srfb_parse.sv
`default_nettype none

// Receive-side frame parser. Each received byte advances the parse state; a
// write frame yields one store write per completed word, a read frame yields
// one report request when its count byte arrives.
module srfb_parse #(
  parameter int unsigned REG_WORDS = 2048
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  byte_en_i,
  input  wire  [7:0]           byte_i,
  output srfb_pkg::srfb_wr_t   wr_o,
  output srfb_pkg::srfb_rpt_t  rpt_o
);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_CMD   = 3'd3;
  localparam logic [2:0] PH_AHI   = 3'd4;
  localparam logic [2:0] PH_ALO   = 3'd5;
  localparam logic [2:0] PH_BODY  = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  seen_q, seen_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  hold_q, hold_d;
  logic [7:0]  wptr_q, wptr_d;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    seen_d  = seen_q;
    cmd_d   = cmd_q;
    addr_d  = addr_q;
    hold_d  = hold_q;
    wptr_d  = wptr_q;
    wr_o    = '0;
    rpt_o   = '0;
    if (byte_en_i) begin
      unique case (phase_q)
        PH_SYNC2: begin
          priority if (byte_i == srfb_pkg::HDR_LO) begin
            phase_d = PH_LEN;
          end else if (byte_i == srfb_pkg::HDR_HI) begin
            phase_d = PH_SYNC2;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_LEN: begin
          len_d   = byte_i;
          seen_d  = 8'd0;
          wptr_d  = 8'd0;
          phase_d = PH_CMD;
        end
        PH_CMD: begin
          cmd_d  = byte_i;
          seen_d = 8'd1;
          if (len_q < 8'd3 || (byte_i == srfb_pkg::CMD_READ && len_q < 8'd4)) begin
            phase_d = PH_HUNT;
          end else begin
            phase_d = PH_AHI;
          end
        end
        PH_AHI: begin
          addr_d  = {byte_i, 8'h00};
          seen_d  = 8'd2;
          phase_d = PH_ALO;
        end
        PH_ALO: begin
          addr_d = {addr_q[15:8], byte_i};
          seen_d = 8'd3;
          if ({1'b0, addr_d} >= srfb_pkg::XADDR_W'(REG_WORDS) || len_q <= 8'd3) begin
            phase_d = PH_HUNT;
          end else begin
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          seen_d = seen_q + 8'd1;
          if (cmd_q == srfb_pkg::CMD_WRITE) begin
            // Payload bytes start at an odd count, so an odd count is a high byte.
            if (seen_q[0]) begin
              hold_d = byte_i;
            end else begin
              wr_o.en   = 1'b1;
              wr_o.addr = {1'b0, addr_q} + srfb_pkg::XADDR_W'(wptr_q);
              wr_o.data = {hold_q, byte_i};
              wptr_d    = wptr_q + 8'd1;
            end
          end else if (cmd_q == srfb_pkg::CMD_READ && seen_q == 8'd3) begin
            rpt_o.en    = 1'b1;
            rpt_o.addr  = addr_q;
            rpt_o.count = byte_i;
          end
          if (seen_d >= len_q) begin
            phase_d = PH_HUNT;
          end
        end
        default: begin
          phase_d = (byte_i == srfb_pkg::HDR_HI) ? PH_SYNC2 : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      seen_q  <= '0;
      cmd_q   <= '0;
      addr_q  <= '0;
      hold_q  <= '0;
      wptr_q  <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      cmd_q   <= cmd_d;
      addr_q  <= addr_d;
      hold_q  <= hold_d;
      wptr_q  <= wptr_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/serial_register_frame_bridge.sv
// A bank of REG_WORDS 16-bit registers reached either from a byte link or from
// the local side. Each input item is a received byte, a local write, a local
// read or a local request for a report frame. Received frames are 5A A5 LEN CMD
// ADDR_HI ADDR_LO payload; command 82 writes big-endian words as they complete
// and command 83 answers with a report frame of up to MAX_READ words. After
// reset the block sweeps zeros through the register store, one entry per cycle,
// and takes no item until the sweep is over. A received byte that produces no
// output and a local write leave the block idle and ready for the next item. A
// local read goes through the registered store read port and the ST_LRD state
// before its word is loaded into the output register. A report frame takes the
// item, sends its seven header bytes and then, for each word, one store read
// and two bytes, high byte first, waiting whenever the output is stalled. The
// output register holds one finished item, so a new input item can be taken
// while the last result is still waiting to be collected.
`default_nettype none

module serial_register_frame_bridge #(
  parameter int unsigned REG_WORDS = 2048,
  parameter int unsigned MAX_READ  = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  srfb_in_if.sink     in_i,
  srfb_out_if.source  out_o
);

  // Width of a saturated word count.
  localparam int unsigned CW = $clog2(MAX_READ + 1);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LRD   = 3'd2;
  localparam logic [2:0] ST_HDR   = 3'd3;
  localparam logic [2:0] ST_WRD   = 3'd4;
  localparam logic [2:0] ST_WHI   = 3'd5;
  localparam logic [2:0] ST_WLO   = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [15:0]   rpt_addr_q, rpt_addr_d;
  logic [CW-1:0] rpt_cnt_q, rpt_cnt_d;
  logic [2:0]    hdr_idx_q, hdr_idx_d;
  logic [CW-1:0] word_idx_q, word_idx_d;

  logic          out_valid_q;
  logic          out_kind_q;
  logic [7:0]    out_byte_q;
  logic [15:0]   out_word_q;
  logic          out_last_q;

  // Output register load strobe and the value it takes.
  logic          ld;
  logic          ld_kind;
  logic [7:0]    ld_byte;
  logic [15:0]   ld_word;
  logic          ld_last;

  logic          out_free;
  logic          accept;
  logic          byte_en;

  srfb_pkg::srfb_wr_t  parse_wr;
  srfb_pkg::srfb_rpt_t parse_rpt;
  srfb_pkg::srfb_wr_t  store_wr;
  srfb_pkg::srfb_rd_t  store_rd;
  logic [15:0]         store_rdata;
  logic                store_busy;

  logic                rpt_start;
  logic [15:0]         rpt_start_addr;
  logic [7:0]          rpt_start_cnt;
  logic                word_last;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign byte_en    = accept && (srfb_pkg::srfb_action_e'(in_i.action) == srfb_pkg::ACT_RX_BYTE);

  // The output register can take a new item when it is empty or being emptied.
  assign out_free  = !out_valid_q || out_o.ready;
  assign word_last = (word_idx_q + CW'(1)) == rpt_cnt_q;

  srfb_parse #(
    .REG_WORDS (REG_WORDS)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (byte_en),
    .byte_i    (in_i.rx_byte),
    .wr_o      (parse_wr),
    .rpt_o     (parse_rpt)
  );

  srfb_store #(
    .REG_WORDS (REG_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (store_wr),
    .rd_i    (store_rd),
    .rdata_o (store_rdata),
    .busy_o  (store_busy)
  );

  always_comb begin
    state_d        = state_q;
    rpt_addr_d     = rpt_addr_q;
    rpt_cnt_d      = rpt_cnt_q;
    hdr_idx_d      = hdr_idx_q;
    word_idx_d     = word_idx_q;
    ld             = 1'b0;
    ld_kind        = srfb_pkg::KIND_TX_BYTE;
    ld_byte        = 8'h00;
    ld_word        = 16'h0000;
    ld_last        = 1'b0;
    store_wr       = '0;
    store_rd       = '0;
    rpt_start      = 1'b0;
    rpt_start_addr = in_i.reg_addr;
    rpt_start_cnt  = in_i.reg_count;

    unique case (state_q)
      ST_CLEAR: begin
        if (!store_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (srfb_pkg::srfb_action_e'(in_i.action))
            srfb_pkg::ACT_RX_BYTE: begin
              store_wr       = parse_wr;
              rpt_start      = parse_rpt.en;
              rpt_start_addr = parse_rpt.addr;
              rpt_start_cnt  = parse_rpt.count;
            end
            srfb_pkg::ACT_WRITE: begin
              store_wr.en   = 1'b1;
              store_wr.addr = {1'b0, in_i.reg_addr};
              store_wr.data = in_i.reg_value;
            end
            srfb_pkg::ACT_READ: begin
              store_rd.en   = 1'b1;
              store_rd.addr = {1'b0, in_i.reg_addr};
              state_d       = ST_LRD;
            end
            srfb_pkg::ACT_REPORT: begin
              rpt_start = 1'b1;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
        if (rpt_start) begin
          rpt_addr_d = rpt_start_addr;
          rpt_cnt_d  = (rpt_start_cnt > 8'(MAX_READ)) ? CW'(MAX_READ)
                                                      : rpt_start_cnt[CW-1:0];
          hdr_idx_d  = 3'd0;
          state_d    = ST_HDR;
        end
      end
      ST_LRD: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_kind = srfb_pkg::KIND_READ_WORD;
          ld_word = store_rdata;
          ld_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_HDR: begin
        if (out_free) begin
          ld = 1'b1;
          unique case (hdr_idx_q)
            3'd0:    ld_byte = srfb_pkg::HDR_HI;
            3'd1:    ld_byte = srfb_pkg::HDR_LO;
            3'd2:    ld_byte = 8'({rpt_cnt_q, 1'b0}) + 8'd4;
            3'd3:    ld_byte = srfb_pkg::CMD_READ;
            3'd4:    ld_byte = rpt_addr_q[15:8];
            3'd5:    ld_byte = rpt_addr_q[7:0];
            default: ld_byte = 8'(rpt_cnt_q);
          endcase
          hdr_idx_d = hdr_idx_q + 3'd1;
          if (hdr_idx_q == 3'd6) begin
            // The count byte closes the frame when no words follow.
            ld_last    = (rpt_cnt_q == '0);
            word_idx_d = '0;
            state_d    = (rpt_cnt_q == '0) ? ST_IDLE : ST_WRD;
          end
        end
      end
      ST_WRD: begin
        store_rd.en   = 1'b1;
        store_rd.addr = {1'b0, rpt_addr_q} + srfb_pkg::XADDR_W'(word_idx_q);
        state_d       = ST_WHI;
      end
      ST_WHI: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_byte = store_rdata[15:8];
          state_d = ST_WLO;
        end
      end
      ST_WLO: begin
        if (out_free) begin
          ld         = 1'b1;
          ld_byte    = store_rdata[7:0];
          ld_last    = word_last;
          word_idx_d = word_idx_q + CW'(1);
          state_d    = word_last ? ST_IDLE : ST_WRD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      rpt_addr_q  <= '0;
      rpt_cnt_q   <= '0;
      hdr_idx_q   <= '0;
      word_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rpt_addr_q <= rpt_addr_d;
      rpt_cnt_q  <= rpt_cnt_d;
      hdr_idx_q  <= hdr_idx_d;
      word_idx_q <= word_idx_d;
      if (ld) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      out_kind_q <= ld_kind;
      out_byte_q <= ld_byte;
      out_word_q <= ld_word;
      out_last_q <= ld_last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_kind   = out_kind_q;
  assign out_o.tx_byte    = out_byte_q;
  assign out_o.read_word  = out_word_q;
  assign out_o.frame_last = out_last_q;

endmodule

`default_nettype wire
